// ----- rtl/twg_pkg.sv -----
// Shared types, register codes and waveform table for the table waveform generator.
// Used by every module under rtl/ but twg_checker; depends on nothing.
package twg_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CountW     = 14;
  localparam int StepW      = 5;
  localparam int DutyW      = 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 14;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KIND   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STEP   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PERIOD = 2'd3;

  // Waveform kinds
  localparam logic [1:0] WAVE_SQUARE   = 2'd0;
  localparam logic [1:0] WAVE_SINE     = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
  localparam logic [1:0] WAVE_SAWTOOTH = 2'd3;

  localparam logic [CountW-1:0] PERIOD_RESET = 14'd15625;

  // Table read request from the counter stage
  typedef struct packed {
    logic            valid;
    logic [1:0]      kind;
    logic [IdxW-1:0] idx;
  } rd_req_t;

  // Result of a table read
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [IdxW-1:0]  pos;
  } sample_t;

  localparam logic [DutyW-1:0] SINE_ROM [64] = '{
    8'd127, 8'd139, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
    8'd217, 8'd226, 8'd233, 8'd239, 8'd245, 8'd249, 8'd252, 8'd254,
    8'd255, 8'd254, 8'd252, 8'd249, 8'd245, 8'd239, 8'd233, 8'd226,
    8'd217, 8'd208, 8'd198, 8'd187, 8'd176, 8'd164, 8'd152, 8'd139,
    8'd127, 8'd115, 8'd102, 8'd90,  8'd78,  8'd67,  8'd56,  8'd46,
    8'd37,  8'd28,  8'd21,  8'd15,  8'd9,   8'd5,   8'd2,   8'd0,
    8'd0,   8'd0,   8'd2,   8'd5,   8'd9,   8'd15,  8'd21,  8'd28,
    8'd37,  8'd46,  8'd56,  8'd67,  8'd78,  8'd90,  8'd102, 8'd115
  };

  // Duty value of table entry i for the given waveform
  function automatic logic [DutyW-1:0] wave_value(logic [1:0] kind, logic [IdxW-1:0] i);
    logic [15:0] prod;
    logic [6:0]  fall;
    logic [1:0]  corr;
    logic [DutyW-1:0] res;
    prod = 16'd0;
    fall = 7'd0;
    corr = 2'd0;
    res  = '0;
    case (kind)
      WAVE_SINE: begin
        res = SINE_ROM[i];
      end
      WAVE_TRIANGLE: begin
        if (i < 6'd32) begin
          prod = 16'd510 * {10'd0, i};
        end else begin
          fall = 7'd64 - {1'b0, i};
          prod = 16'd510 * {9'd0, fall};
        end
        res = prod[13:6];
      end
      WAVE_SAWTOOTH: begin
        // 255*i/63 = 4*i + i/21 over the index range
        if (i < 6'd21)      corr = 2'd0;
        else if (i < 6'd42) corr = 2'd1;
        else if (i < 6'd63) corr = 2'd2;
        else                corr = 2'd3;
        res = {i, 2'b00} + {6'd0, corr};
      end
      default: begin
        res = (i < 6'd32) ? 8'd255 : 8'd0;
      end
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/table_waveform_generator.sv -----
// Top level of the table waveform generator.
// Depends on twg_pkg, twg_ctrl, twg_rom and twg_out.
//
// Usage:
//   Input stream s_*: one beat per microsecond tick; s_tdata[0] = 1 requests a
//   restart (clears table index and tick count, no sample), 0 is a plain tick.
//   Output stream m_*: one beat per emitted sample, duty value and table index.
//   Configuration: cfg_we/cfg_index/cfg_data write enable (0), wave kind (1),
//   phase step (2) and sample period in ticks (3); write only while idle.
// Timing:
//   One input beat per cycle, sustained while the receiver keeps m_tready high.
//   The sample of the tick that completes the period passes the table read
//   register, then the output register, to m_tvalid; the counter/address stage
//   is combinational.
// Reset (rst, synchronous): counters clear, the pipeline empties, registers
//   return to disabled, sine, step 1, period 15625.
// Stall: while the receiver holds m_tready low, the output register and the
//   table stage keep their beats; s_tready falls only when both are full.
module table_waveform_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [0] restart, [7:1] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [7:0] duty_sample, [13:8] table_position
  input  logic                          cfg_we,
  input  logic [twg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [twg_pkg::CfgDataW-1:0]  cfg_data
);

  twg_pkg::rd_req_t  req;
  twg_pkg::sample_t  rd_data;
  logic              rd_valid;
  logic              out_take;
  logic              advance;
  logic              beat;

  // Table stage moves when empty or when the output register takes it
  assign advance  = !rd_valid || out_take;
  assign s_tready = advance;
  assign beat     = s_tvalid && s_tready;

  twg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .beat      (beat),
    .restart   (s_tdata[0]),
    .req       (req)
  );

  twg_rom u_rom (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .advance  (advance),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  twg_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .in_data  (rd_data),
    .take     (out_take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/twg_ctrl.sv -----
// Configuration registers, tick counter and table index for the waveform generator.
// Depends on twg_pkg; issues one table read request per emitted sample.
module twg_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [twg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [twg_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          beat,
  input  logic                          restart,
  output twg_pkg::rd_req_t              req
);

  logic                          enable;
  logic [1:0]                    wave_kind;
  logic [twg_pkg::StepW-1:0]     phase_step;
  logic [twg_pkg::CountW-1:0]    sample_period;
  logic [twg_pkg::IdxW-1:0]      sample_index;
  logic [twg_pkg::IdxW-1:0]      sample_index_next;
  logic [twg_pkg::CountW-1:0]    tick_count;
  logic [twg_pkg::CountW-1:0]    tick_count_next;
  logic [twg_pkg::CountW-1:0]    tick_inc;
  logic [twg_pkg::CountW-1:0]    period_eff;
  logic                          emit;

  // Hold configuration; write on the enable strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      wave_kind     <= twg_pkg::WAVE_SINE;
      phase_step    <= twg_pkg::StepW'(1);
      sample_period <= twg_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        twg_pkg::REG_ENABLE: enable        <= cfg_data[0];
        twg_pkg::REG_KIND:   wave_kind     <= cfg_data[1:0];
        twg_pkg::REG_STEP:   phase_step    <= cfg_data[twg_pkg::StepW-1:0];
        twg_pkg::REG_PERIOD: sample_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count ticks and decide whether this beat emits a sample
  always_comb begin
    tick_inc          = tick_count + twg_pkg::CountW'(1);
    period_eff        = (sample_period == '0) ? twg_pkg::CountW'(1) : sample_period;
    emit              = 1'b0;
    tick_count_next   = tick_count;
    sample_index_next = sample_index;
    if (restart) begin
      tick_count_next   = '0;
      sample_index_next = '0;
    end else if (enable) begin
      if (tick_inc != '0 && tick_inc < period_eff) begin
        tick_count_next = tick_inc;
      end else begin
        emit              = 1'b1;
        tick_count_next   = '0;
        sample_index_next = sample_index
                          + twg_pkg::IdxW'({{(twg_pkg::IdxW){1'b0}}, phase_step});
      end
    end
  end

  // Advance counters on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      sample_index <= '0;
    end else if (beat) begin
      tick_count   <= tick_count_next;
      sample_index <= sample_index_next;
    end
  end

  assign req.valid = beat & emit;
  assign req.kind  = wave_kind;
  assign req.idx   = sample_index;

endmodule

// ----- rtl/twg_rom.sv -----
// Synchronous waveform table with a registered read and its valid stage.
// Depends on twg_pkg; the table contents come from twg_pkg::wave_value.
module twg_rom (
  input  logic              clk,
  input  logic              rst,
  input  twg_pkg::rd_req_t  req,
  input  logic              advance,
  output logic              rd_valid,
  output twg_pkg::sample_t  rd_data
);

  logic [twg_pkg::DutyW-1:0] table_mem [4*twg_pkg::TableDepth];
  logic [twg_pkg::IdxW+1:0]  addr;

  // Table image indexed by {kind, entry}
  always_comb begin
    for (int k = 0; k < 4*twg_pkg::TableDepth; k++) begin
      table_mem[k] = twg_pkg::wave_value(2'(k / twg_pkg::TableDepth),
                                         twg_pkg::IdxW'(k % twg_pkg::TableDepth));
    end
  end

  assign addr = {req.kind, req.idx};

  // Register the read; hold while the next stage is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (advance) begin
      rd_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data.duty <= table_mem[addr];
      rd_data.pos  <= req.idx;
    end
  end

endmodule

// ----- rtl/twg_out.sv -----
// Output register of the waveform generator; parts the table stage from the receiver.
// Depends on twg_pkg for the sample type.
module twg_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  twg_pkg::sample_t  in_data,
  output logic              take,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata
);

  twg_pkg::sample_t held;

  // Load when empty or when the receiver takes the current beat
  assign take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= in_data;
    end
  end

  assign m_tdata = {2'b00, held.pos, held.duty};

endmodule

// ----- rtl/twg_checker.sv -----
// Port-level checks for the table waveform generator, bound to the top level.
// Depends only on the top level's ports.
module twg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat present after reset");

  // A receiver that takes beats never stalls the input side
  a_ready_flow: assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input stalled while output ready");

  // Padding bits of an output beat stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:14] == 2'b00)
    else $error("nonzero padding in output beat");

  // A stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

endmodule

bind table_waveform_generator twg_checker u_twg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/tb_table_waveform_generator.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for table_waveform_generator: streams tick and restart beats,
// predicts every duty sample in a cycle-free model and checks the output stream in order.
// Depends on rtl/twg_pkg.sv and rtl/table_waveform_generator.sv.
module tb_table_waveform_generator;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 700;
  localparam int MAX_REPORTS   = 10;

  // Sine table, floor(127.5 + 127.5*sin(2*pi*i/64))
  localparam logic [7:0] SINE_TABLE [64] = '{
    8'd127, 8'd139, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
    8'd217, 8'd226, 8'd233, 8'd239, 8'd245, 8'd249, 8'd252, 8'd254,
    8'd255, 8'd254, 8'd252, 8'd249, 8'd245, 8'd239, 8'd233, 8'd226,
    8'd217, 8'd208, 8'd198, 8'd187, 8'd176, 8'd164, 8'd152, 8'd139,
    8'd127, 8'd115, 8'd102, 8'd90,  8'd78,  8'd67,  8'd56,  8'd46,
    8'd37,  8'd28,  8'd21,  8'd15,  8'd9,   8'd5,   8'd2,   8'd0,
    8'd0,   8'd0,   8'd2,   8'd5,   8'd9,   8'd15,  8'd21,  8'd28,
    8'd37,  8'd46,  8'd56,  8'd67,  8'd78,  8'd90,  8'd102, 8'd115
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = 8'd0;    // [0] restart, [7:1] zero
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [15:0]                   m_tdata;           // [7:0] duty_sample, [13:8] table_position
  logic                          cfg_we = 1'b0;
  logic [twg_pkg::CfgIdxW-1:0]   cfg_index = twg_pkg::REG_ENABLE;
  logic [twg_pkg::CfgDataW-1:0]  cfg_data = '0;

  table_waveform_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Pending tick/restart beats and the duty samples they are expected to produce
  bit               tick_q[$];
  twg_pkg::sample_t duty_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int beats_pushed   = 0;
  int beats_accepted = 0;
  int restarts_seen  = 0;
  int samples_ok     = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  // Generator model state and registers
  logic                         gen_enable;
  logic [1:0]                   gen_kind;
  logic [twg_pkg::StepW-1:0]    gen_step;
  logic [twg_pkg::CountW-1:0]   gen_period;
  logic [twg_pkg::IdxW-1:0]     gen_index;
  logic [twg_pkg::CountW-1:0]   gen_ticks;
  twg_pkg::sample_t             new_sample;
  twg_pkg::sample_t             want;

  function automatic logic [7:0] duty_of(logic [1:0] kind, logic [twg_pkg::IdxW-1:0] pos);
    int unsigned n;
    int unsigned v;
    n = pos;
    case (kind)
      twg_pkg::WAVE_SINE:     v = SINE_TABLE[n];
      twg_pkg::WAVE_TRIANGLE: v = (n < 32) ? (510 * n) / 64 : (510 * (64 - n)) / 64;
      twg_pkg::WAVE_SAWTOOTH: v = (255 * n) / 63;
      default:                v = (n < 32) ? 255 : 0;
    endcase
    return v[7:0];
  endfunction

  // Drive input beats from the pending queue, with random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick_q.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the output at random; a requested hold keeps tready low for a long stretch
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Track register writes and accepted beats; queue the expected samples
  always @(posedge clk) begin
    if (rst) begin
      gen_enable = 1'b0;
      gen_kind   = twg_pkg::WAVE_SINE;
      gen_step   = twg_pkg::StepW'(1);
      gen_period = twg_pkg::PERIOD_RESET;
      gen_index  = '0;
      gen_ticks  = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          twg_pkg::REG_ENABLE: gen_enable = cfg_data[0];
          twg_pkg::REG_KIND:   gen_kind   = cfg_data[1:0];
          twg_pkg::REG_STEP:   gen_step   = cfg_data[twg_pkg::StepW-1:0];
          twg_pkg::REG_PERIOD: gen_period = cfg_data[twg_pkg::CountW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tdata[0]) begin
          gen_index = '0;
          gen_ticks = '0;
          restarts_seen++;
        end else if (gen_enable) begin
          gen_ticks = gen_ticks + 1'b1;
          // a zero period behaves as one tick
          if (gen_ticks == 0 || gen_ticks >= ((gen_period == 0) ? 1 : gen_period)) begin
            gen_ticks       = '0;
            new_sample.duty = duty_of(gen_kind, gen_index);
            new_sample.pos  = gen_index;
            duty_q.push_back(new_sample);
            gen_index = gen_index + {1'b0, gen_step};
          end
        end
        beats_accepted++;
      end
    end
  end

  // Compare each output beat with the oldest expected sample
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (duty_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected sample: duty %0d position %0d", m_tdata[7:0], m_tdata[13:8]);
      end else begin
        want = duty_q.pop_front();
        if (want.duty !== m_tdata[7:0] || want.pos !== m_tdata[13:8]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("sample mismatch: duty exp %0d got %0d, position exp %0d got %0d",
                     want.duty, m_tdata[7:0], want.pos, m_tdata[13:8]);
        end else begin
          samples_ok++;
        end
      end
    end
  end

  // Abort when no beat of any kind moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [twg_pkg::CfgIdxW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[twg_pkg::CfgDataW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_beat(bit restart);
    tick_q.push_back(restart);
    beats_pushed++;
  endtask

  task automatic push_ticks(int n, int restart_pct);
    for (int k = 0; k < n; k++)
      push_beat($urandom_range(99) < restart_pct);
  endtask

  // Wait until every beat is taken and every sample has come, then let the pipe settle
  task automatic drain();
    wait (beats_accepted == beats_pushed && duty_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // New settings, then a run of ticks with occasional restarts
  task automatic random_run(int n);
    int unsigned step_val;
    int unsigned period_val;
    if ($urandom_range(3) != 0) step_val = 1 << $urandom_range(4);
    else step_val = $urandom_range(31);
    case ($urandom_range(9))
      0:       period_val = $urandom_range(16383);
      1, 2:    period_val = $urandom_range(40);
      default: period_val = $urandom_range(6);
    endcase
    write_reg(twg_pkg::REG_ENABLE, $urandom_range(9) != 0);
    write_reg(twg_pkg::REG_KIND, $urandom_range(3));
    write_reg(twg_pkg::REG_STEP, step_val);
    write_reg(twg_pkg::REG_PERIOD, period_val);
    push_ticks(n, 4);
    drain();
  endtask

  int phase_send [4] = '{0, 75, 0, 9};
  int phase_recv [4] = '{0, 0, 75, 9};
  int random_done = 0;
  int run_len;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset: ticks and a restart give nothing
    push_ticks(3, 0);
    push_beat(1'b1);
    drain();

    // Reset settings: sine, step 1, period 15625, so a short run stays silent
    write_reg(twg_pkg::REG_ENABLE, 1);
    push_ticks(40, 0);
    drain();

    // Lower the period below the running count: next tick fires
    write_reg(twg_pkg::REG_PERIOD, 16383);
    push_ticks(20, 0);
    drain();
    write_reg(twg_pkg::REG_PERIOD, 3);
    push_ticks(1, 0);
    drain();

    // Longest period: a short run after a restart stays silent
    write_reg(twg_pkg::REG_PERIOD, 16383);
    push_beat(1'b1);
    push_ticks(40, 0);
    drain();

    // Zero period with zero step: same entry on every tick
    write_reg(twg_pkg::REG_PERIOD, 0);
    write_reg(twg_pkg::REG_STEP, 0);
    push_ticks(3, 0);
    drain();

    // Restart in the middle of a period
    write_reg(twg_pkg::REG_PERIOD, 5);
    write_reg(twg_pkg::REG_STEP, 1);
    push_ticks(3, 0);
    push_beat(1'b1);
    push_ticks(5, 0);
    drain();

    // Disabled ticks hold the count
    write_reg(twg_pkg::REG_PERIOD, 4);
    push_ticks(2, 0);
    drain();
    write_reg(twg_pkg::REG_ENABLE, 0);
    push_ticks(3, 0);
    drain();
    write_reg(twg_pkg::REG_ENABLE, 1);
    push_ticks(2, 0);
    drain();

    // Sweep the whole table of every waveform
    write_reg(twg_pkg::REG_PERIOD, 1);
    for (int k = 0; k < 4; k++) begin
      write_reg(twg_pkg::REG_KIND, k);
      push_beat(1'b1);
      push_ticks(64, 0);
      drain();
    end

    // Random runs under each idling mix
    for (int p = 0; p < 4; p++) begin
      set_idling(phase_send[p], phase_recv[p]);
      if (p == 0) begin
        // Hold the output long enough for the block to back up its input
        write_reg(twg_pkg::REG_ENABLE, 1);
        write_reg(twg_pkg::REG_PERIOD, 1);
        write_reg(twg_pkg::REG_KIND, $urandom_range(3));
        hold_asks <= hold_asks + 1;
        push_ticks(200, 2);
        drain();
      end
      while (random_done < (p + 1) * RANDOM_ITEMS / 4) begin
        run_len = $urandom_range(20, 80);
        random_run(run_len);
        random_done += run_len;
      end
    end

    set_idling(0, 0);
    drain();
    $display("run covered %0d beats (%0d restarts) and %0d checked samples", beats_accepted,
             restarts_seen, samples_ok);
    $display("all four waveforms, period and step extremes, four idle mixes, one long output hold");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
